// ===== src/lbb_pkg.sv =====
// shared types and constants for the logo bitmap line blitter
package lbb_pkg;

   // fixed field widths of the stream and result beats
   localparam int BYTE_W    = 8;
   localparam int COLUMN_W  = 9;
   localparam int LINE_W    = 11;
   localparam int BYTE_COL_W = 6;

   // packed widths on the result channel
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // one result beat as it leaves the parser
   typedef struct packed {
      logic                  write_valid;
      logic                  second_valid;
      logic [LINE_W-1:0]     dot_line;
      logic [BYTE_COL_W-1:0] byte_column;
      logic [BYTE_W-1:0]     first_part;
      logic [BYTE_W-1:0]     second_part;
      logic                  image_done;
      logic                  status;
   } result_type;

endpackage

// ===== src/lbb_parser.sv =====
// logo stream parser: row/length state, bit-aligned placement and line advance
module lbb_parser #(
   parameter int LINE_BYTES = 48,
   parameter int MAX_LINES  = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           beat_accept,
   input  logic [lbb_pkg::BYTE_W-1:0]     stream_byte,
   input  logic                           image_start,
   input  logic [lbb_pkg::COLUMN_W-1:0]   start_column,
   output lbb_pkg::result_type            result,
   output logic                           result_valid
);

   // parse phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEN_HI = 2'd1;
   localparam logic [1:0] PH_LEN_LO = 2'd2;
   localparam logic [1:0] PH_DATA   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  rows_left_ff, rows_left_in;
   logic [15:0] row_length_ff, row_length_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [11:0] current_line_ff, current_line_in;
   logic        oom_ff, oom_in;

   logic [5:0]  lbytes;
   logic [2:0]  lbits;
   logic [16:0] index_next;
   logic [9:0]  col;
   logic [12:0] line_next;
   logic [7:0]  rows_dec;
   logic [15:0] shifted;
   logic [15:0] length_full;
   logic        finish;

   // next state and result for the accepted beat
   always_comb begin
      phase_in        = phase_ff;
      rows_left_in    = rows_left_ff;
      row_length_in   = row_length_ff;
      byte_index_in   = byte_index_ff;
      current_line_in = current_line_ff;
      oom_in          = oom_ff;
      result          = '0;
      result_valid    = 1'b0;
      finish          = 1'b0;

      lbytes      = start_column[8:3];
      lbits       = start_column[2:0];
      index_next  = {1'b0, byte_index_ff} + 17'd1;
      col         = {4'd0, lbytes} + {2'd0, byte_index_ff[7:0]};
      line_next   = {1'b0, current_line_ff} + 13'd1;
      rows_dec    = rows_left_ff - 8'd1;
      shifted     = {stream_byte, 8'h00} >> lbits;
      length_full = {row_length_ff[15:8], stream_byte};

      if (beat_accept) begin
         priority if (image_start) begin
            if (oom_ff) begin
               // refused image: done with out-of-memory status
               phase_in          = PH_IDLE;
               result.image_done = 1'b1;
               result.status     = 1'b1;
               result_valid      = 1'b1;
            end else begin
               rows_left_in  = stream_byte;
               row_length_in = '0;
               byte_index_in = '0;
               if (stream_byte == 8'd0) begin
                  phase_in          = PH_IDLE;
                  result.image_done = 1'b1;
                  result_valid      = 1'b1;
               end else begin
                  phase_in = PH_LEN_HI;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  // stray byte outside an image
               end
               PH_LEN_HI: begin
                  row_length_in = {stream_byte, 8'h00};
                  phase_in      = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  row_length_in = length_full;
                  byte_index_in = '0;
                  if (length_full == 16'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  // keep the byte only while it fits the line
                  if (byte_index_ff < 16'(LINE_BYTES) && col < 10'(LINE_BYTES)) begin
                     result.write_valid  = 1'b1;
                     result.second_valid = (col + 10'd1) < 10'(LINE_BYTES);
                     result.dot_line     = current_line_ff[10:0];
                     result.byte_column  = col[5:0];
                     result.first_part   = shifted[15:8];
                     result.second_part  = shifted[7:0];
                     result_valid        = 1'b1;
                  end
                  byte_index_in = index_next[15:0];
                  if (index_next >= {1'b0, row_length_ff}) begin
                     finish = 1'b1;
                  end
               end
            endcase
         end
      end

      // end of row: advance the line, check limit and remaining rows
      if (finish) begin
         rows_left_in    = rows_dec;
         current_line_in = line_next[11:0];
         if (line_next >= 13'(MAX_LINES)) begin
            oom_in            = 1'b1;
            phase_in          = PH_IDLE;
            result.image_done = 1'b1;
            result.status     = 1'b1;
            result_valid      = 1'b1;
         end else if (rows_dec == 8'd0) begin
            phase_in          = PH_IDLE;
            result.image_done = 1'b1;
            result_valid      = 1'b1;
         end else begin
            phase_in = PH_LEN_HI;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         rows_left_ff    <= '0;
         row_length_ff   <= '0;
         byte_index_ff   <= '0;
         current_line_ff <= '0;
         oom_ff          <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         rows_left_ff    <= rows_left_in;
         row_length_ff   <= row_length_in;
         byte_index_ff   <= byte_index_in;
         current_line_ff <= current_line_in;
         oom_ff          <= oom_in;
      end
   end

endmodule

// ===== src/lbb_skid.sv =====
// result register with a skid stage so the input side keeps flowing
module lbb_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lbb_pkg::result_type push_data,
   output logic                push_ready,
   output logic                out_valid,
   output lbb_pkg::result_type out_data,
   input  logic                out_ready
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   lbb_pkg::result_type out_data_ff, out_data_in;
   lbb_pkg::result_type skid_data_ff, skid_data_in;
   logic                pop;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   // fill and drain of the two slots
   always_comb begin
      pop           = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== src/logo_bitmap_line_blitter.sv =====
// top level of the logo bitmap line blitter
//
// Streams a monochrome logo in one byte per req beat: the beat with req_tuser
// high carries the row count, then each row comes as a big-endian 16-bit length
// and that many bitmap bytes. Kept bytes leave on the rsp channel as OR-writes
// (line, byte column, two shifted parts); the beat that ends the logo has
// rsp_tlast high and carries the status (0 ok, 1 out of memory).
// csr carries the start column; write it only while the block is idle.
// Throughput is one req beat per cycle while req_tready is high.
// A result is registered in the result register, or in the skid stage when
// that is full. Beats that produce no write and no end of logo give no rsp beat.
// The result register has a skid stage behind it: req_tready stays high while
// one result waits, and drops only once both slots hold results the receiver
// has not taken. Nothing is lost or repeated while rsp_tready is low.
// Reset clears the parse state, the line counter, the out-of-memory flag and
// the start column; req_tready is high as reset is released.
module logo_bitmap_line_blitter #(
   parameter int LINE_BYTES = 48,
   parameter int MAX_LINES  = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: stream_byte[7:0]
   input  logic [7:0]                        req_tdata,
   // req_tuser: image_start[0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: dot_line[10:0], byte_column[16:11], first_part[24:17],
   //            second_part[32:25], status[33], zero fill[39:34]
   output logic [lbb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: write_valid[0], second_valid[1]
   output logic [lbb_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [lbb_pkg::COLUMN_W-1:0]      csr_data,
   input  logic                              csr_valid,
   output logic                              csr_ready
);

   logic [lbb_pkg::COLUMN_W-1:0] start_column_ff;
   logic                         beat_accept;
   lbb_pkg::result_type          parse_result;
   logic                         parse_valid;
   lbb_pkg::result_type          rsp_result;

   assign csr_ready   = 1'b1;
   assign beat_accept = req_tvalid && req_tready;

   // start column register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         start_column_ff <= csr_data;
      end
   end

   lbb_parser #(
      .LINE_BYTES (LINE_BYTES),
      .MAX_LINES  (MAX_LINES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .stream_byte  (req_tdata),
      .image_start  (req_tuser),
      .start_column (start_column_ff),
      .result       (parse_result),
      .result_valid (parse_valid)
   );

   lbb_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (beat_accept && parse_valid),
      .push_data  (parse_result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_result),
      .out_ready  (rsp_tready)
   );

   // pack the result beat
   assign rsp_tdata = {6'd0, rsp_result.status, rsp_result.second_part,
                       rsp_result.first_part, rsp_result.byte_column,
                       rsp_result.dot_line};
   assign rsp_tuser = {rsp_result.second_valid, rsp_result.write_valid};
   assign rsp_tlast = rsp_result.image_done;

endmodule

// ===== dv/tb_logo_bitmap_line_blitter.sv =====
// self-checking testbench for the logo bitmap line blitter
`timescale 1ns / 100ps

module tb_logo_bitmap_line_blitter;

   localparam int LINE_BYTES = 48;
   localparam int MAX_LINES  = 2048;

   // parser position inside a logo stream
   typedef enum logic [1:0] {
      WAIT_IMAGE,
      WANT_LEN_HI,
      WANT_LEN_LO,
      IN_BITMAP
   } stream_pos_type;

   // one stream beat, optionally with its result typed in by hand
   typedef struct packed {
      logic [7:0]          data;
      logic                start;
      logic                typed;
      logic                want_hit;
      lbb_pkg::result_type want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [7:0]                     req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lbb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [lbb_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                           rsp_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lbb_pkg::COLUMN_W-1:0]   csr_data = '0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;

   // blitter state as the testbench sees it
   stream_pos_type stream_pos = WAIT_IMAGE;
   logic [7:0]     rows_pending = '0;
   logic [15:0]    len_of_row = '0;
   logic [15:0]    bitmap_idx = '0;
   logic [11:0]    line_now = '0;
   logic           mem_full = 1'b0;
   logic [8:0]     col_setting = '0;

   lbb_pkg::result_type pending_blits[$];
   stim_row_type        directed_rows[$];
   stim_row_type        cur_row = '0;
   int                  fail_count = 0;
   int                  beats_sent = 0;
   int                  burst_left = 0;
   int                  gap_max = 3;
   int                  stall_pct = 25;
   int                  hold_left = 0;

   logo_bitmap_line_blitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // advance to the next line after a row; returns 1 when the logo ends
   function automatic bit close_row(output logic st);
      logic [12:0] nxt;
      nxt = line_now + 13'd1;
      rows_pending = rows_pending - 8'd1;
      line_now = nxt[11:0];
      st = 1'b0;
      if (nxt >= MAX_LINES) begin
         mem_full = 1'b1;
         stream_pos = WAIT_IMAGE;
         st = 1'b1;
         return 1'b1;
      end
      if (rows_pending == 8'd0) begin
         stream_pos = WAIT_IMAGE;
         return 1'b1;
      end
      stream_pos = WANT_LEN_HI;
      return 1'b0;
   endfunction

   // work out the blit write or end of logo caused by one stream byte
   function automatic bit blit_predict(input logic [7:0] b, input logic s,
                                       output lbb_pkg::result_type r);
      int   lbytes;
      int   lbits;
      int   j;
      int   col;
      logic st;
      bit   hit;
      r = '0;
      hit = 1'b0;
      lbytes = col_setting[8:3];
      lbits = col_setting[2:0];
      if (s) begin
         if (mem_full) begin
            // refused logo: nothing but the status changes hands
            stream_pos = WAIT_IMAGE;
            r.image_done = 1'b1;
            r.status = 1'b1;
            hit = 1'b1;
         end else begin
            rows_pending = b;
            len_of_row = '0;
            bitmap_idx = '0;
            if (b == 8'd0) begin
               stream_pos = WAIT_IMAGE;
               r.image_done = 1'b1;
               hit = 1'b1;
            end else begin
               stream_pos = WANT_LEN_HI;
            end
         end
      end else begin
         case (stream_pos)
            WANT_LEN_HI: begin
               len_of_row = {b, 8'h00};
               stream_pos = WANT_LEN_LO;
            end
            WANT_LEN_LO: begin
               len_of_row[7:0] = b;
               bitmap_idx = '0;
               if (len_of_row == 16'd0) begin
                  if (close_row(st)) begin
                     r.image_done = 1'b1;
                     r.status = st;
                     hit = 1'b1;
                  end
               end else begin
                  stream_pos = IN_BITMAP;
               end
            end
            IN_BITMAP: begin
               j = bitmap_idx;
               col = lbytes + j;
               // only bytes that land inside the line are written
               if (j < LINE_BYTES && col < LINE_BYTES) begin
                  r.write_valid = 1'b1;
                  r.second_valid = (col + 1 < LINE_BYTES);
                  r.dot_line = line_now[10:0];
                  r.byte_column = col[5:0];
                  r.first_part = b >> lbits;
                  r.second_part = (lbits == 0) ? 8'h00 : (b << (8 - lbits));
                  hit = 1'b1;
               end
               bitmap_idx = bitmap_idx + 16'd1;
               if (j + 1 >= len_of_row) begin
                  if (close_row(st)) begin
                     r.image_done = 1'b1;
                     r.status = st;
                     hit = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      return hit;
   endfunction

   function automatic stim_row_type plain(input logic [7:0] b, input logic s);
      plain = '0;
      plain.data = b;
      plain.start = s;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] b, input logic s,
                                              input logic hit,
                                              input lbb_pkg::result_type want);
      typed_row = '0;
      typed_row.data = b;
      typed_row.start = s;
      typed_row.typed = 1'b1;
      typed_row.want_hit = hit;
      typed_row.want = want;
   endfunction

   function automatic lbb_pkg::result_type done_beat(input logic st);
      done_beat = '0;
      done_beat.image_done = 1'b1;
      done_beat.status = st;
   endfunction

   // stream beats go out in bursts with random gaps in between while gap_max is nonzero
   task automatic send_beat(input stim_row_type row);
      int gap;
      @(negedge clock);
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if (gap_max > 0) begin
         gap = $urandom_range(1, gap_max);
         burst_left = $urandom_range(0, 15);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_row = row;
      req_tdata <= row.data;
      req_tuser <= row.start;
      req_tvalid <= 1'b1;
      beats_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_sending;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained;
      while (pending_blits.size() != 0) @(posedge clock);
   endtask

   // start column writes happen only with the stream stopped and all results drained
   task automatic csr_write(input logic [8:0] v);
      stop_sending();
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      col_setting = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one logo; full mode also makes empty, huge and abandoned logos
   task automatic send_image(input bit full);
      int rows;
      int rows_sent;
      int len;
      int cut;
      int r;
      int i;
      int v;
      v = $urandom_range(99);
      if (full && v < 6) rows = 0;
      else if (full && v < 12) rows = $urandom_range(128, 255);
      else rows = $urandom_range(1, 5);
      rows_sent = (rows > 5) ? $urandom_range(1, 3) : rows;
      send_beat(plain(rows[7:0], 1'b1));
      for (r = 0; r < rows_sent; r++) begin
         v = $urandom_range(99);
         if (v < 8) len = 0;
         else if (v < 70) len = $urandom_range(1, 6);
         else if (v < 95) len = $urandom_range(40, 56);
         else len = $urandom_range(256, 300);
         cut = (full && $urandom_range(99) < 4) ? $urandom_range(len) : -1;
         send_beat(plain(len[15:8], 1'b0));
         send_beat(plain(len[7:0], 1'b0));
         for (i = 0; i < len; i++) begin
            // an abandoned logo is cut off by the next start mark
            if (i == cut) return;
            send_beat(plain(8'($urandom_range(255)), 1'b0));
         end
      end
   endtask

   // receiver holds ready high or low for random stretches
   always @(negedge clock) begin
      if (hold_left == 0) begin
         rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
         hold_left <= $urandom_range(6);
      end else begin
         hold_left <= hold_left - 1;
      end
   end

   // predict on every accepted stream beat
   always @(posedge clock) begin : stream_monitor
      lbb_pkg::result_type predicted;
      bit                  hit;
      if (!reset && req_tvalid && req_tready) begin
         hit = blit_predict(req_tdata, req_tuser, predicted);
         if (cur_row.typed) begin
            hit = cur_row.want_hit;
            predicted = cur_row.want;
         end
         if (hit) pending_blits.push_back(predicted);
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin : result_monitor
      lbb_pkg::result_type got;
      lbb_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.write_valid = rsp_tuser[0];
         got.second_valid = rsp_tuser[1];
         got.dot_line = rsp_tdata[10:0];
         got.byte_column = rsp_tdata[16:11];
         got.first_part = rsp_tdata[24:17];
         got.second_part = rsp_tdata[32:25];
         got.status = rsp_tdata[33];
         got.image_done = rsp_tlast;
         if (pending_blits.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with nothing expected, expected none, got %h",
                     $time, got);
         end else begin
            want = pending_blits.pop_front();
            check_field("write_valid", 16'(want.write_valid), 16'(got.write_valid));
            check_field("second_valid", 16'(want.second_valid), 16'(got.second_valid));
            check_field("dot_line", 16'(want.dot_line), 16'(got.dot_line));
            check_field("byte_column", 16'(want.byte_column), 16'(got.byte_column));
            check_field("first_part", 16'(want.first_part), 16'(got.first_part));
            check_field("second_part", 16'(want.second_part), 16'(got.second_part));
            check_field("image_done", 16'(want.image_done), 16'(got.image_done));
            check_field("status", 16'(want.status), 16'(got.status));
         end
      end
   end

   initial begin
      #8000000;
      $display("FAIL logo_bitmap_line_blitter");
      $finish;
   end

   initial begin : stimulus
      int p;
      int phase_end;
      logic [8:0] col;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at the reset start column
      directed_rows.push_back(typed_row(8'h5A, 1'b0, 1'b0, '0));       // stray byte while idle
      directed_rows.push_back(typed_row(8'h00, 1'b1, 1'b1, done_beat(1'b0))); // empty logo
      directed_rows.push_back(plain(8'h02, 1'b1));
      directed_rows.push_back(plain(8'h00, 1'b0));
      directed_rows.push_back(plain(8'h02, 1'b0));
      directed_rows.push_back(plain(8'hFF, 1'b0));
      directed_rows.push_back(plain(8'h80, 1'b0));
      directed_rows.push_back(plain(8'h00, 1'b0));
      directed_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, done_beat(1'b0))); // zero-length row
      directed_rows.push_back(plain(8'hFF, 1'b1));
      directed_rows.push_back(plain(8'hFF, 1'b0));
      directed_rows.push_back(plain(8'hFF, 1'b0));
      directed_rows.push_back(plain(8'h01, 1'b0));
      directed_rows.push_back(plain(8'h01, 1'b1));                     // restart mid-logo
      directed_rows.push_back(plain(8'h00, 1'b0));
      directed_rows.push_back(plain(8'h01, 1'b0));
      directed_rows.push_back(plain(8'h7F, 1'b0));
      directed_rows.push_back(typed_row(8'hA5, 1'b0, 1'b0, '0));
      foreach (directed_rows[k]) send_beat(directed_rows[k]);

      // random logos over a sweep of start columns and idle patterns
      for (p = 0; p < 8; p++) begin
         case (p)
            0: col = 9'd383;
            1: col = 9'd7;
            2: col = 9'd511;
            3: col = 9'd376;
            4: col = 9'd0;
            5: col = 9'd129;
            default: col = 9'($urandom_range(511));
         endcase
         csr_write(col);
         gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 4 : 12);
         stall_pct = (p % 4) * 25;
         phase_end = beats_sent + 35;
         while (beats_sent < phase_end) begin
            if ($urandom_range(99) < 10) begin
               repeat ($urandom_range(1, 3))
                  send_beat(plain(8'($urandom_range(255)), 1'b0));
            end
            if ($urandom_range(99) < 4) begin
               stop_sending();
               wait_drained();
            end
            send_image(1'b1);
         end
      end

      stop_sending();
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS logo_bitmap_line_blitter");
      else
         $display("FAIL logo_bitmap_line_blitter");
      $finish;
   end

endmodule
